[rtl/core/http_chunked_body_decoder_unit_defines.svh]
// Assertion macros for the chunked body decoder.
// Uses clk and rst_n of the module that includes this file.
`ifndef HTTP_CHUNKED_BODY_DECODER_UNIT_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_UNIT_DEFINES_SVH

// Property holds on the same edge as its antecedent.
`define HCBD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property holds on the edge after its antecedent.
`define HCBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/hcbd_pkg.sv]
// Shared codes and helpers for the chunked body decoder.
// No dependencies.
package hcbd_pkg;

    localparam int unsigned PHASE_W = 3;
    localparam int unsigned BODY_W  = 24;

    localparam logic [PHASE_W-1:0] PH_SIZE      = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SIZE_LF   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SIZE_SKIP = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DATA      = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DATA_SKIP = 3'd4;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;

    localparam logic [BODY_W-1:0] MAX_BODY_RESET = 24'hFFFFFF;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] b);
        hex_digit_t r;
        r.ok    = 1'b1;
        r.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            r.value = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            r.value = 4'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            r.value = 4'(b - 8'h37);
        end
        else
        begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

[rtl/core/http_chunked_body_decoder_unit.sv]
// Chunked body decoder: one stream byte per beat, at most one result per beat.
// The accepted byte is held in byte_reg; its result goes to output registers.
// Throughput: one byte per cycle from the update stage unless out_stall blocks.
// Reset (rst_n low, asynchronous): decoder returns to a fresh size line,
// body count zero, max_body_bytes register to 0xFFFFFF; output empties.
// Depends on hcbd_pkg and http_chunked_body_decoder_unit_defines.svh.
`include "http_chunked_body_decoder_unit_defines.svh"

module http_chunked_body_decoder_unit
    import hcbd_pkg::*;
#(
    parameter int unsigned SIZE_DIGITS = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [BODY_W-1:0] max_body_bytes,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        stream_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        result_kind,
    output logic [7:0]        payload_byte,
    output logic [BODY_W-1:0] body_length
);

    localparam int unsigned ACC_W = 4 * SIZE_DIGITS;
    localparam int unsigned DC_W  = $clog2(SIZE_DIGITS + 1);
    localparam int unsigned SUM_W = ((ACC_W > BODY_W) ? ACC_W : BODY_W) + 1;

    logic [BODY_W-1:0]  max_body_reg;

    logic               in_valid_reg;
    logic [7:0]         byte_reg;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [DC_W-1:0]    digit_count_reg, digit_count_next;
    logic               still_hex_reg, still_hex_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [ACC_W-1:0]   remaining_reg, remaining_next;
    logic [1:0]         lec_reg, lec_next;
    logic [BODY_W-1:0]  body_count_reg, body_count_next;

    logic               out_valid_reg, out_valid_next;
    logic [1:0]         kind_reg;
    logic [7:0]         payload_reg;
    logic [BODY_W-1:0]  length_reg;

    logic               emit;
    logic [1:0]         emit_kind;
    logic [7:0]         emit_payload;
    logic [BODY_W-1:0]  emit_length;

    logic               out_free;
    logic               advance;
    logic               accept;
    logic               load_out;

    hex_digit_t         hd;
    logic [DC_W-1:0]    dc_inc;
    logic [1:0]         lec_track;
    logic               line_done;
    logic               have_digit;
    logic [SUM_W-1:0]   sum_len;
    logic [BODY_W-1:0]  body_inc;
    logic [ACC_W-1:0]   rem_dec;

    assign cfg_ready = 1'b1;

    assign hd        = hex_decode(byte_reg);
    assign dc_inc    = digit_count_reg + DC_W'(1);
    assign body_inc  = body_count_reg + BODY_W'(1);
    assign rem_dec   = (remaining_reg != '0) ? (remaining_reg - ACC_W'(1)) : remaining_reg;
    assign have_digit = still_hex_reg ? (digit_count_reg != '0) : 1'b1;
    assign sum_len   = SUM_W'(body_count_reg) + SUM_W'(acc_reg);

    always_comb
    begin
        if (byte_reg == CH_CR)
        begin
            lec_track = 2'd1;
        end
        else if (byte_reg == CH_LF)
        begin
            lec_track = (lec_reg == 2'd0) ? 2'd1 : 2'd2;
        end
        else
        begin
            lec_track = 2'd0;
        end
    end

    assign line_done = (lec_track == 2'd2);

    always_comb
    begin
        phase_next       = phase_reg;
        digit_count_next = digit_count_reg;
        still_hex_next   = still_hex_reg;
        acc_next         = acc_reg;
        remaining_next   = remaining_reg;
        lec_next         = lec_reg;
        body_count_next  = body_count_reg;
        emit             = 1'b0;
        emit_kind        = KIND_DATA;
        emit_payload     = 8'd0;
        emit_length      = body_count_reg;

        case (phase_reg)
            PH_SIZE:
            begin
                if (byte_reg == CH_SEMI)
                begin
                    phase_next = PH_SIZE_SKIP;
                    lec_next   = 2'd0;
                end
                else if (byte_reg == CH_CR)
                begin
                    phase_next = PH_SIZE_LF;
                end
                else
                begin
                    if (still_hex_reg)
                    begin
                        if (hd.ok)
                        begin
                            acc_next = (acc_reg << 4) | ACC_W'(hd.value);
                        end
                        else
                        begin
                            still_hex_next = 1'b0;
                        end
                    end
                    digit_count_next = dc_inc;
                    if (dc_inc >= DC_W'(SIZE_DIGITS))
                    begin
                        phase_next = PH_SIZE_SKIP;
                        lec_next   = 2'd0;
                    end
                end
            end
            PH_SIZE_LF, PH_SIZE_SKIP:
            begin
                if (phase_reg == PH_SIZE_SKIP)
                begin
                    lec_next = lec_track;
                end
                if (phase_reg == PH_SIZE_LF && byte_reg != CH_LF)
                begin
                    emit      = 1'b1;
                    emit_kind = KIND_ERROR;
                end
                else if (phase_reg == PH_SIZE_LF || line_done)
                begin
                    if (!have_digit || acc_reg == '0)
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_DONE;
                    end
                    else if (sum_len > SUM_W'(max_body_reg))
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_ERROR;
                    end
                    else
                    begin
                        remaining_next = acc_reg;
                        phase_next     = PH_DATA;
                    end
                end
                if (emit)
                begin
                    phase_next       = PH_SIZE;
                    digit_count_next = '0;
                    still_hex_next   = 1'b1;
                    acc_next         = '0;
                    remaining_next   = '0;
                    lec_next         = 2'd0;
                    body_count_next  = '0;
                end
            end
            PH_DATA:
            begin
                body_count_next = body_inc;
                remaining_next  = rem_dec;
                if (rem_dec == '0)
                begin
                    phase_next = PH_DATA_SKIP;
                    lec_next   = 2'd0;
                end
                emit         = 1'b1;
                emit_kind    = KIND_DATA;
                emit_payload = byte_reg;
                emit_length  = body_inc;
            end
            PH_DATA_SKIP:
            begin
                lec_next = lec_track;
                if (line_done)
                begin
                    phase_next       = PH_SIZE;
                    digit_count_next = '0;
                    still_hex_next   = 1'b1;
                    acc_next         = '0;
                    lec_next         = 2'd0;
                end
            end
            default:
            begin
                phase_next       = PH_SIZE;
                digit_count_next = '0;
                still_hex_next   = 1'b1;
                acc_next         = '0;
                remaining_next   = '0;
                lec_next         = 2'd0;
                body_count_next  = '0;
            end
        endcase
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && (out_free || !emit);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign load_out = advance && emit;

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_body_reg    <= MAX_BODY_RESET;
            in_valid_reg    <= 1'b0;
            phase_reg       <= PH_SIZE;
            digit_count_reg <= '0;
            still_hex_reg   <= 1'b1;
            acc_reg         <= '0;
            remaining_reg   <= '0;
            lec_reg         <= 2'd0;
            body_count_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                max_body_reg <= max_body_bytes;
            end
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                phase_reg       <= phase_next;
                digit_count_reg <= digit_count_next;
                still_hex_reg   <= still_hex_next;
                acc_reg         <= acc_next;
                remaining_reg   <= remaining_next;
                lec_reg         <= lec_next;
                body_count_reg  <= body_count_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= stream_byte;
        end
        if (load_out)
        begin
            kind_reg    <= emit_kind;
            payload_reg <= emit_payload;
            length_reg  <= emit_length;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign payload_byte = payload_reg;
    assign body_length  = length_reg;

    `HCBD_ASSERT_SAME(a_kind_legal, out_valid_reg,
        kind_reg == KIND_DATA || kind_reg == KIND_DONE || kind_reg == KIND_ERROR,
        "illegal result kind")
    `HCBD_ASSERT_SAME(a_payload_zero, out_valid_reg && kind_reg != KIND_DATA,
        payload_reg == 8'd0, "payload set on done or error beat")
    `HCBD_ASSERT_SAME(a_data_remaining, phase_reg == PH_DATA,
        remaining_reg != '0, "data phase with nothing remaining")
    `HCBD_ASSERT_NEXT(a_restart, load_out && emit_kind != KIND_DATA,
        phase_reg == PH_SIZE && body_count_reg == '0, "no restart after done or error")
    `HCBD_ASSERT_NEXT(a_out_hold, out_valid_reg && out_stall,
        out_valid_reg && $stable(length_reg), "stalled result lost")

endmodule
